// File: sv/gps_pkg.sv
// gps_pkg: shared types and constants of the polar-method gaussian sampler
// no dependencies; imported by every module of the block
package gps_pkg;

  localparam int GPS_UNIFORM_WIDTH = 32;
  localparam int GPS_FRACTION_BITS = 16;
  localparam int GPS_LOG_BITS      = 56;
  localparam int GPS_DIV_BITS      = 60;
  localparam int GPS_ROOT_BITS     = 60;
  localparam int GPS_QUEUE_DEPTH   = 2;

  // 2*ln(2) in Q1.62
  localparam logic [63:0] GPS_TWO_LN2 = 64'h58B9_0BFB_E8E7_BCD6;

  // configuration register indexes
  localparam logic GPS_CFG_MEAN   = 1'b0;
  localparam logic GPS_CFG_SPREAD = 1'b1;

  // one accepted pair: squared magnitudes, their sum and the signs
  typedef struct packed {
    logic [62:0] sx;
    logic [62:0] sy;
    logic [62:0] r;
    logic        nx;
    logic        ny;
  } gps_job_t;

  // request to the shared multiplier
  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } gps_mul_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NORM,
    ST_LOG,
    ST_LOG_W,
    ST_PREP,
    ST_DIV,
    ST_GQ,
    ST_GQ_W,
    ST_LN2,
    ST_LN2_W,
    ST_SQRT,
    ST_SPR,
    ST_SPR_W,
    ST_OUT
  } gps_state_t;

endpackage

// File: sv/gps_mul.sv
// gps_mul: 64x64 unsigned multiplier built from one 32x32 multiplier, one partial product at a time
// depends on gps_pkg
module gps_mul
  import gps_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  gps_mul_req_t  req,
  output logic          done,
  output logic [127:0]  prod
);

  logic         busy_r;
  logic [2:0]   cnt_r;
  logic         done_r;
  logic [63:0]  a_r;
  logic [63:0]  b_r;
  logic [63:0]  pp_r;
  logic [127:0] acc_r;

  logic [31:0]  a_half;
  logic [31:0]  b_half;
  logic [63:0]  pp_nxt;
  logic [1:0]   prev_idx;
  logic [127:0] pp_shift;

  // partial product order: lo*lo, lo*hi, hi*lo, hi*hi
  always_comb begin
    a_half = cnt_r[1] ? a_r[63:32] : a_r[31:0];
    b_half = cnt_r[0] ? b_r[63:32] : b_r[31:0];
    pp_nxt = a_half * b_half;
    prev_idx = cnt_r[1:0] - 2'd1;
    case (prev_idx)
      2'd0:    pp_shift = {64'd0, pp_r};
      2'd3:    pp_shift = {pp_r, 64'd0};
      default: pp_shift = {32'd0, pp_r, 32'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 3'd0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 3'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'd4) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= req.a;
      b_r   <= req.b;
      acc_r <= 128'd0;
    end else if (busy_r) begin
      if (cnt_r != 3'd4) pp_r <= pp_nxt;
      if (cnt_r != 3'd0) acc_r <= acc_r + pp_shift;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// File: sv/gps_fifo.sv
// gps_fifo: short register queue of accepted pairs between front and back
// depends on gps_pkg
module gps_fifo
  import gps_pkg::*;
#(
  parameter int DEPTH = GPS_QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  gps_job_t push_job,
  input  logic     pop,
  output logic     full,
  output logic     not_empty,
  output gps_job_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  gps_job_t        mem_r [DEPTH];
  logic [AW-1:0]   wp_r;
  logic [AW-1:0]   rp_r;
  logic [CW-1:0]   cnt_r;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ptr_inc(wp_r);
      if (pop)  rp_r <= ptr_inc(rp_r);
      if (push && !pop) cnt_r <= cnt_r + CW'(1);
      else if (pop && !push) cnt_r <= cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_job;
  end

  assign full      = (cnt_r == CW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rp_r];

endmodule

// File: sv/gps_front.sv
// gps_front: takes uniform pairs, forms offsets and squares, drops rejected pairs
// depends on gps_pkg; feeds gps_fifo
module gps_front
  import gps_pkg::*;
#(
  parameter int UNIFORM_WIDTH = GPS_UNIFORM_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [UNIFORM_WIDTH-1:0] in_uniform_a,
  input  logic [UNIFORM_WIDTH-1:0] in_uniform_b,
  input  logic                     q_full,
  output logic                     q_push,
  output gps_job_t                 q_job
);

  logic [31:0] ua32;
  logic [31:0] ub32;

  generate
    if (UNIFORM_WIDTH >= 32) begin : g_wide
      assign ua32 = in_uniform_a[UNIFORM_WIDTH-1 -: 32];
      assign ub32 = in_uniform_b[UNIFORM_WIDTH-1 -: 32];
    end else begin : g_narrow
      assign ua32 = {in_uniform_a, {(32-UNIFORM_WIDTH){1'b0}}};
      assign ub32 = {in_uniform_b, {(32-UNIFORM_WIDTH){1'b0}}};
    end
  endgenerate

  logic        s1_v_r;
  logic [31:0] mx_r;
  logic [31:0] my_r;
  logic        s1_nx_r;
  logic        s1_ny_r;
  logic        s2_v_r;
  logic [62:0] sx_r;
  logic [62:0] sy_r;
  logic        s2_nx_r;
  logic        s2_ny_r;

  logic        in_go;
  logic        s1_go;
  logic        s2_go;
  logic [62:0] r_sum;
  logic        reject;
  logic [63:0] sqx;
  logic [63:0] sqy;

  always_comb begin
    r_sum  = sx_r + sy_r;
    // zero radius or outside the unit circle
    reject = (r_sum == 63'd0) || (r_sum > (63'd1 << 62));
    s2_go  = s2_v_r && (reject || !q_full);
    s1_go  = s1_v_r && (!s2_v_r || s2_go);
    in_stall = s1_v_r && !s1_go;
    in_go  = in_valid && !in_stall;
    sqx    = mx_r * mx_r;
    sqy    = my_r * my_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (in_go) s1_v_r <= 1'b1;
      else if (s1_go) s1_v_r <= 1'b0;
      if (s1_go) s2_v_r <= 1'b1;
      else if (s2_go) s2_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_go) begin
      s1_nx_r <= !ua32[31];
      s1_ny_r <= !ub32[31];
      mx_r    <= ua32[31] ? {1'b0, ua32[30:0]} : 32'h8000_0000 - ua32;
      my_r    <= ub32[31] ? {1'b0, ub32[30:0]} : 32'h8000_0000 - ub32;
    end
    if (s1_go) begin
      sx_r    <= sqx[62:0];
      sy_r    <= sqy[62:0];
      s2_nx_r <= s1_nx_r;
      s2_ny_r <= s1_ny_r;
    end
  end

  assign q_push   = s2_v_r && !reject && !q_full;
  assign q_job.sx = sx_r;
  assign q_job.sy = sy_r;
  assign q_job.r  = r_sum;
  assign q_job.nx = s2_nx_r;
  assign q_job.ny = s2_ny_r;

endmodule

// File: sv/gps_back.sv
// gps_back: sequencer for log, divide, scale, root and output of both samples
// depends on gps_pkg and gps_mul
module gps_back
  import gps_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  input  gps_job_t           job,
  output logic               job_pop,
  input  logic signed [31:0] mean_value,
  input  logic [30:0]        spread,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_sample,
  output logic               out_clipped,
  output logic               out_last_of_pair
);

  localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
  localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

  gps_state_t   state_r, state_nxt;
  gps_job_t     job_r, job_nxt;
  logic [62:0]  m_r, m_nxt;
  logic [5:0]   s_r, s_nxt;
  logic [63:0]  z_r, z_nxt;
  logic [55:0]  frac_r, frac_nxt;
  logic [5:0]   cnt_r, cnt_nxt;
  logic [61:0]  g_r, g_nxt;
  logic [63:0]  rem_r, rem_nxt;
  logic [60:0]  q_r, q_nxt;
  logic [63:0]  t_r, t_nxt;
  logic [119:0] rad_r, rad_nxt;
  logic [59:0]  root_r, root_nxt;
  logic [63:0]  mag_r, mag_nxt;
  logic         sel_r, sel_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [31:0]  out_sample_r, out_sample_nxt;
  logic         out_clip_r, out_clip_nxt;
  logic         out_last_r, out_last_nxt;

  gps_mul_req_t mreq;
  logic         mdone;
  logic [127:0] mprod;

  gps_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .done  (mdone),
    .prod  (mprod)
  );

  logic [63:0]  log_sq;
  logic [55:0]  log_frac;
  logic [62:0]  num;
  logic [63:0]  rem2;
  logic [63:0]  rem4;
  logic [63:0]  trial;
  logic [127:0] rounded;
  logic         neg;
  logic signed [65:0] v;
  logic         slot_free;

  always_comb begin
    log_sq    = mprod[125:62];
    log_frac  = {frac_r[54:0], log_sq[63]};
    num       = sel_r ? job_r.sx : job_r.sy;
    rem2      = {rem_r[62:0], 1'b0};
    rem4      = {rem_r[61:0], rad_r[119:118]};
    trial     = {2'b00, root_r, 2'b01};
    rounded   = mprod + (128'd1 << 55);
    neg       = sel_r ? job_r.nx : job_r.ny;
    v         = neg ? ($signed({{34{mean_value[31]}}, mean_value}) - $signed({2'b00, mag_r}))
                    : ($signed({{34{mean_value[31]}}, mean_value}) + $signed({2'b00, mag_r}));
    slot_free = !out_valid_r || !out_stall;
  end

  always_comb begin
    state_nxt      = state_r;
    job_nxt        = job_r;
    m_nxt          = m_r;
    s_nxt          = s_r;
    z_nxt          = z_r;
    frac_nxt       = frac_r;
    cnt_nxt        = cnt_r;
    g_nxt          = g_r;
    rem_nxt        = rem_r;
    q_nxt          = q_r;
    t_nxt          = t_r;
    rad_nxt        = rad_r;
    root_nxt       = root_r;
    mag_nxt        = mag_r;
    sel_nxt        = sel_r;
    out_sample_nxt = out_sample_r;
    out_clip_nxt   = out_clip_r;
    out_last_nxt   = out_last_r;
    out_valid_nxt  = out_valid_r && out_stall;
    job_pop        = 1'b0;
    mreq.start     = 1'b0;
    mreq.a         = z_r;
    mreq.b         = z_r;

    unique case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          job_pop   = 1'b1;
          job_nxt   = job;
          m_nxt     = job.r;
          s_nxt     = 6'd0;
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        // shift until the top bit is set, one place a cycle
        if (m_r[62]) begin
          z_nxt     = {1'b0, m_r};
          frac_nxt  = 56'd0;
          cnt_nxt   = 6'd0;
          state_nxt = ST_LOG;
        end else begin
          m_nxt = {m_r[61:0], 1'b0};
          s_nxt = s_r + 6'd1;
        end
      end
      ST_LOG: begin
        mreq.start = 1'b1;
        state_nxt  = ST_LOG_W;
      end
      ST_LOG_W: begin
        if (mdone) begin
          frac_nxt = log_frac;
          z_nxt    = log_sq[63] ? {1'b0, log_sq[63:1]} : log_sq;
          if (cnt_r == 6'(GPS_LOG_BITS - 1)) begin
            // -log2(r2) in Q6.56
            g_nxt     = {s_r, 56'd0} - {6'd0, log_frac};
            sel_nxt   = 1'b0;
            state_nxt = ST_PREP;
          end else begin
            cnt_nxt   = cnt_r + 6'd1;
            state_nxt = ST_LOG;
          end
        end
      end
      ST_PREP: begin
        if (num >= job_r.r) begin
          q_nxt     = 61'd1 << 60;
          state_nxt = ST_GQ;
        end else begin
          rem_nxt   = {1'b0, num};
          q_nxt     = 61'd0;
          cnt_nxt   = 6'd0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (rem2 >= {1'b0, job_r.r}) begin
          rem_nxt = rem2 - {1'b0, job_r.r};
          q_nxt   = {q_r[59:0], 1'b1};
        end else begin
          rem_nxt = rem2;
          q_nxt   = {q_r[59:0], 1'b0};
        end
        if (cnt_r == 6'(GPS_DIV_BITS - 1)) state_nxt = ST_GQ;
        else cnt_nxt = cnt_r + 6'd1;
      end
      ST_GQ: begin
        mreq.start = 1'b1;
        mreq.a     = {2'b00, g_r};
        mreq.b     = {3'b000, q_r};
        state_nxt  = ST_GQ_W;
      end
      ST_GQ_W: begin
        if (mdone) begin
          t_nxt     = mprod[123:60];
          state_nxt = ST_LN2;
        end
      end
      ST_LN2: begin
        mreq.start = 1'b1;
        mreq.a     = t_r;
        mreq.b     = GPS_TWO_LN2;
        state_nxt  = ST_LN2_W;
      end
      ST_LN2_W: begin
        if (mdone) begin
          // radicand is t times 2*ln(2), scaled by 2^112
          rad_nxt   = {mprod[125:62], 56'd0};
          rem_nxt   = 64'd0;
          root_nxt  = 60'd0;
          cnt_nxt   = 6'd0;
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (rem4 >= trial) begin
          rem_nxt  = rem4 - trial;
          root_nxt = {root_r[58:0], 1'b1};
        end else begin
          rem_nxt  = rem4;
          root_nxt = {root_r[58:0], 1'b0};
        end
        rad_nxt = {rad_r[117:0], 2'b00};
        if (cnt_r == 6'(GPS_ROOT_BITS - 1)) state_nxt = ST_SPR;
        else cnt_nxt = cnt_r + 6'd1;
      end
      ST_SPR: begin
        mreq.start = 1'b1;
        mreq.a     = {4'd0, root_r};
        mreq.b     = {33'd0, spread};
        state_nxt  = ST_SPR_W;
      end
      ST_SPR_W: begin
        if (mdone) begin
          mag_nxt   = rounded[119:56];
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = sel_r;
          if (v > SAT_HI) begin
            out_sample_nxt = 32'h7FFF_FFFF;
            out_clip_nxt   = 1'b1;
          end else if (v < SAT_LO) begin
            out_sample_nxt = 32'h8000_0000;
            out_clip_nxt   = 1'b1;
          end else begin
            out_sample_nxt = v[31:0];
            out_clip_nxt   = 1'b0;
          end
          if (sel_r) begin
            state_nxt = ST_IDLE;
          end else begin
            sel_nxt   = 1'b1;
            state_nxt = ST_PREP;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r        <= job_nxt;
    m_r          <= m_nxt;
    s_r          <= s_nxt;
    z_r          <= z_nxt;
    frac_r       <= frac_nxt;
    cnt_r        <= cnt_nxt;
    g_r          <= g_nxt;
    rem_r        <= rem_nxt;
    q_r          <= q_nxt;
    t_r          <= t_nxt;
    rad_r        <= rad_nxt;
    root_r       <= root_nxt;
    mag_r        <= mag_nxt;
    sel_r        <= sel_nxt;
    out_sample_r <= out_sample_nxt;
    out_clip_r   <= out_clip_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_sample       = out_sample_r;
  assign out_clipped      = out_clip_r;
  assign out_last_of_pair = out_last_r;

endmodule

// File: sv/gaussian_polar_sampler_unit.sv
// Polar-method gaussian sampler: each word is a pair of uniform draws; a pair inside
// the unit circle gives two Q16.16 samples (y-based, then x-based with last_of_pair
// set), a pair outside or at zero gives none. The front takes a word every cycle
// unless the two-entry queue it feeds is full; the back works on one kept pair at a
// time, its pace set by its one 32x32 multiplier that forms each of its products (the
// 56 squarings of the log lead), by the one-bit-a-cycle divide and root loops and by
// output stall; a coordinate of zero skips one divide. Rejected pairs never reach the back.
// depends on gps_pkg, gps_front, gps_fifo, gps_back
module gaussian_polar_sampler_unit
  import gps_pkg::*;
#(
  parameter int UNIFORM_WIDTH = GPS_UNIFORM_WIDTH,
  parameter int FRACTION_BITS = GPS_FRACTION_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [UNIFORM_WIDTH-1:0] in_uniform_a,
  input  logic [UNIFORM_WIDTH-1:0] in_uniform_b,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [31:0]       out_sample,
  output logic                     out_clipped,
  output logic                     out_last_of_pair,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [31:0]              cfg_wdata
);

  logic signed [31:0] mean_r;
  logic [30:0]        spread_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r   <= 32'sd0;
      spread_r <= 31'd1 << FRACTION_BITS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        GPS_CFG_MEAN:   mean_r   <= cfg_wdata;
        GPS_CFG_SPREAD: spread_r <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  logic     q_full;
  logic     q_push;
  logic     q_pop;
  logic     q_not_empty;
  gps_job_t q_in;
  gps_job_t q_head;

  gps_front #(
    .UNIFORM_WIDTH (UNIFORM_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_uniform_a (in_uniform_a),
    .in_uniform_b (in_uniform_b),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_job        (q_in)
  );

  gps_fifo #(
    .DEPTH (GPS_QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  gps_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .job_valid        (q_not_empty),
    .job              (q_head),
    .job_pop          (q_pop),
    .mean_value       (mean_r),
    .spread           (spread_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample       (out_sample),
    .out_clipped      (out_clipped),
    .out_last_of_pair (out_last_of_pair)
  );

endmodule
